// ===== src/bdr_pkg.sv =====
// Shared types and codes for the byte-lane data RAM.
`default_nettype none
package bdr_pkg;

  localparam int unsigned LANES = 4;

  // Access kind
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Access size
  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;

  // Lane control from the merge logic to the banks
  typedef struct packed {
    logic [LANES-1:0] lane_we;
    logic             misaligned;
  } lane_ctl_t;

endpackage
`default_nettype wire

// ===== src/bdr_ram.sv =====
// Generic single-port synchronous RAM with registered read.
`default_nettype none
module bdr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== src/bdr_lane_merge.sv =====
// Lane enables, write-data placement, misalignment check and read-data shift.
`default_nettype none
module bdr_lane_merge
  import bdr_pkg::*;
(
  input  wire logic        command,
  input  wire logic [1:0]  offset,
  input  wire logic [1:0]  access_size,
  input  wire logic [31:0] write_data,
  input  wire logic [31:0] old_word,
  output lane_ctl_t        ctl,
  output logic      [31:0] lane_wdata,
  output logic      [31:0] result
);

  logic [LANES-1:0] lanes;
  logic [LANES-1:0] lane_sel;
  logic             bad;
  logic [4:0]       bit_shift;

  assign bit_shift = {offset, 3'b000};

  always_comb begin
    unique case (access_size)
      SZ_BYTE: begin
        lanes = 4'b0001;
        bad   = 1'b0;
      end
      SZ_HALF: begin
        lanes = 4'b0011;
        bad   = (offset == 2'd3);
      end
      default: begin
        // size three decodes as word
        lanes = 4'b1111;
        bad   = (offset != 2'd0);
      end
    endcase
  end

  assign lane_sel       = LANES'(lanes << offset);
  assign ctl.misaligned = bad;
  assign ctl.lane_we    = (command == CMD_WRITE && !bad) ? lane_sel : '0;
  assign lane_wdata     = write_data << bit_shift;
  // writes return the old word unshifted
  assign result         = (command == CMD_WRITE) ? old_word : (old_word >> bit_shift);

endmodule
`default_nettype wire

// ===== src/byte_lane_data_ram_top.sv =====
// Top level of the byte-lane data RAM: four byte banks, access sequencer, output register.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | command, byte_address, write_data, access_size
//  out_    | output    | out_valid/out_stall| read_data, misaligned
//
// The banks are read on acceptance; the old word is back in the following cycle,
// when lanes are written and the result is loaded.
// No new access is taken while the previous one is in the read state.
// rst_n clears control only; bank contents are undefined until written.
// A stalled result blocks new input; a result being taken frees the slot at once.
// WORDS must be a power of two.
`default_nettype none
module byte_lane_data_ram_top
  import bdr_pkg::*;
#(
  parameter int unsigned WORDS = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_command,
  input  wire logic [13:0] in_byte_address,
  input  wire logic [31:0] in_write_data,
  input  wire logic [1:0]  in_access_size,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [31:0] out_read_data,
  output logic             out_misaligned
);

  localparam int unsigned AW = $clog2(WORDS);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RD   = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  logic          cmd_r;
  logic [1:0]    off_r;
  logic [1:0]    size_r;
  logic [31:0]   wdata_r;
  logic [AW-1:0] idx_r;

  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   out_read_data_r;
  logic          out_misaligned_r;

  logic          in_accept;
  logic [AW+13:0] addr_ext;
  logic [AW-1:0] in_idx;
  logic [AW-1:0] bank_addr;
  logic [31:0]   old_word;
  logic [31:0]   lane_wdata;
  logic [31:0]   result;
  lane_ctl_t     ctl;
  logic          in_rd;

  // zero-extend so the index select stays legal for any depth
  assign addr_ext  = {AW'(0), in_byte_address};
  assign in_idx    = addr_ext[AW+1:2];
  assign in_rd     = (state_r == ST_RD);
  assign bank_addr = in_rd ? idx_r : in_idx;

  assign in_stall  = in_rd | (out_valid_r & out_stall);
  assign in_accept = in_valid & ~in_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_accept) state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (in_rd) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r   <= in_command;
      off_r   <= in_byte_address[1:0];
      size_r  <= in_access_size;
      wdata_r <= in_write_data;
      idx_r   <= in_idx;
    end
    if (in_rd) begin
      out_read_data_r  <= result;
      out_misaligned_r <= ctl.misaligned;
    end
  end

  bdr_lane_merge u_merge (
    .command     (cmd_r),
    .offset      (off_r),
    .access_size (size_r),
    .write_data  (wdata_r),
    .old_word    (old_word),
    .ctl         (ctl),
    .lane_wdata  (lane_wdata),
    .result      (result)
  );

  for (genvar i = 0; i < LANES; i++) begin : g_bank
    // lane write only in the read state, so no read of the same word overlaps it
    bdr_ram #(
      .WIDTH (8),
      .DEPTH (WORDS)
    ) u_bank (
      .clk   (clk),
      .we    (in_rd & ctl.lane_we[i]),
      .addr  (bank_addr),
      .wdata (lane_wdata[8*i +: 8]),
      .rdata (old_word[8*i +: 8])
    );
  end

  assign out_valid      = out_valid_r;
  assign out_read_data  = out_read_data_r;
  assign out_misaligned = out_misaligned_r;

endmodule
`default_nettype wire

// ===== src/bdr_checker.sv =====
// Port-level checker for the byte-lane data RAM, bound to the top level.
`default_nettype none
module bdr_checker
  import bdr_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [13:0] in_byte_address,
  input wire logic [1:0]  in_access_size,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_read_data,
  input wire logic        out_misaligned
);

  logic in_acc;
  assign in_acc = in_valid & ~in_stall;

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_data) && $stable(out_misaligned))
    else $error("stalled result changed");

  // result appears once the read state has loaded the output register, slot empty in between
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !out_valid && in_stall ##1 out_valid)
    else $error("result timing wrong");

  a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_access_size == SZ_BYTE |-> ##2 !out_misaligned)
    else $error("byte access flagged misaligned");

  a_word_bad: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_access_size == SZ_WORD && in_byte_address[1:0] != 2'd0
      |-> ##2 out_misaligned)
    else $error("misaligned word not flagged");

endmodule

bind byte_lane_data_ram_top bdr_checker u_bdr_checker (.*);
`default_nettype wire

// ===== tb/byte_lane_data_ram_top_tb.sv =====
// Self-checking testbench for the byte-lane data RAM: directed table, then random accesses.
module byte_lane_data_ram_top_tb;
  import bdr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WORDS        = 4096;
  localparam int          RANDOM_ITEMS = 1450;
  localparam int          IDLE_LIMIT   = 1000;
  localparam int          DRAIN_CYCLES = 10;
  // size code three, decodes as a word
  localparam logic [1:0]  SZ_ALT_WORD  = 2'd3;

  typedef struct packed {
    logic        cmd;
    logic [13:0] addr;
    logic [31:0] wdata;
    logic [1:0]  size;
  } access_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [31:0] valid_bits;  // bits of read_data that hold defined data
    logic        misaligned;
  } ram_result_t;

  typedef struct packed {
    access_t     acc;
    bit          typed;
    logic [31:0] read_data;
    logic        misaligned;
  } table_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_command = CMD_READ;
  logic [13:0] in_byte_address = '0;
  logic [31:0] in_write_data = '0;
  logic [1:0]  in_access_size = SZ_WORD;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_read_data;
  logic        out_misaligned;

  // memory image and per-lane written flags
  logic [31:0] word_image [WORDS];
  bit   [3:0]  lane_known [WORDS];
  bit          in_pool    [WORDS];
  int          known_words[$];

  ram_result_t pending_results[$];
  table_row_t  directed_rows[$];
  int          errors = 0;
  int          burst_left = 0;
  int          idle_cycles = 0;
  int          stall_mode = 0;
  int          stall_phase_left = 0;
  int          stall_tick = 0;

  byte_lane_data_ram_top #(
    .WORDS(WORDS)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_byte_address(in_byte_address),
    .in_write_data  (in_write_data),
    .in_access_size (in_access_size),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_data  (out_read_data),
    .out_misaligned (out_misaligned)
  );

  always #1 clk = ~clk;

  // Works out the result of one access and updates the memory image.
  function automatic ram_result_t predict_access(access_t a);
    int          idx;
    int          off;
    int          nbytes;
    logic [31:0] old_word;
    logic [31:0] known_bits;
    logic [31:0] lane_mask;
    bit   [3:0]  lanes_hit;
    ram_result_t r;
    idx        = int'(a.addr[13:2]) % WORDS;
    off        = int'(a.addr[1:0]);
    nbytes     = (a.size == SZ_BYTE) ? 1 : (a.size == SZ_HALF) ? 2 : 4;
    old_word   = word_image[idx];
    known_bits = {{8{lane_known[idx][3]}}, {8{lane_known[idx][2]}},
                  {8{lane_known[idx][1]}}, {8{lane_known[idx][0]}}};
    r.misaligned = (off + nbytes > 4);
    if (a.cmd == CMD_WRITE) begin
      r.read_data  = old_word;
      r.valid_bits = known_bits;
      if (!r.misaligned) begin
        lane_mask = (nbytes == 4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * nbytes)) - 32'd1);
        lane_mask = lane_mask << (8 * off);
        word_image[idx] = (old_word & ~lane_mask) | ((a.wdata << (8 * off)) & lane_mask);
        lanes_hit = 4'(((32'd1 << nbytes) - 32'd1) << off);
        lane_known[idx] = lane_known[idx] | lanes_hit;
      end
    end else begin
      r.read_data  = old_word >> (8 * off);
      // zeros shifted in from the top are defined
      r.valid_bits = (known_bits >> (8 * off)) | ~(32'hFFFF_FFFF >> (8 * off));
    end
    return r;
  endfunction

  function automatic void add_row(logic cmd, logic [13:0] addr, logic [31:0] wdata,
                                  logic [1:0] size, bit typed, logic [31:0] rdata,
                                  logic mis);
    table_row_t row;
    row.acc.cmd    = cmd;
    row.acc.addr   = addr;
    row.acc.wdata  = wdata;
    row.acc.size   = size;
    row.typed      = typed;
    row.read_data  = rdata;
    row.misaligned = mis;
    directed_rows.push_back(row);
  endfunction

  // Drives one access in a burst; returns at the falling edge after acceptance.
  task automatic send_access(access_t a, bit typed, logic [31:0] rdata, logic mis);
    ram_result_t r;
    int          idx;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 60);
    end
    burst_left--;
    in_valid        <= 1'b1;
    in_command      <= a.cmd;
    in_byte_address <= a.addr;
    in_write_data   <= a.wdata;
    in_access_size  <= a.size;
    do @(posedge clk); while (in_stall);
    r = predict_access(a);
    if (typed) begin
      r.read_data  = rdata;
      r.valid_bits = 32'hFFFF_FFFF;
      r.misaligned = mis;
    end
    pending_results.push_back(r);
    idx = int'(a.addr[13:2]) % WORDS;
    if (lane_known[idx] == 4'hF && !in_pool[idx]) begin
      in_pool[idx] = 1'b1;
      known_words.push_back(idx);
    end
    @(negedge clk);
  endtask

  // Receiver stall pattern, whose mode changes at random from phase to phase.
  always @(negedge clk) begin
    if (stall_phase_left == 0) begin
      stall_mode       = $urandom_range(0, 3);
      stall_phase_left = $urandom_range(20, 300);
    end
    stall_phase_left--;
    stall_tick++;
    case (stall_mode)
      0: begin
        out_stall <= 1'b0;
      end
      1: begin
        out_stall <= ($urandom_range(0, 99) < 30);
      end
      2: begin
        out_stall <= ($urandom_range(0, 99) < 70);
      end
      default: begin
        out_stall <= (stall_tick % 5 == 2);
      end
    endcase
  end

  // Result checker
  always @(posedge clk) begin
    ram_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected transaction: read_data %h misaligned %b",
               out_read_data, out_misaligned);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if ((out_read_data & exp_r.valid_bits) !== (exp_r.read_data & exp_r.valid_bits)) begin
          $error("read_data: expected %h (defined bits %h), got %h",
                 exp_r.read_data, exp_r.valid_bits, out_read_data);
          errors++;
        end
        if (out_misaligned !== exp_r.misaligned) begin
          $error("misaligned: expected %b, got %b", exp_r.misaligned, out_misaligned);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    access_t    acc;
    table_row_t row;
    int         idx;
    logic [1:0] off;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // first touch of a word is a full write; its old contents are undefined
    add_row(CMD_WRITE, 14'h0000, 32'hFFFF_FFFF, SZ_WORD, 0, '0, 1'b0);
    add_row(CMD_WRITE, 14'h3FFC, 32'h0000_0000, SZ_WORD, 0, '0, 1'b0);
    add_row(CMD_READ,  14'h0000, 32'h0000_0000, SZ_WORD, 1, 32'hFFFF_FFFF, 1'b0);
    add_row(CMD_READ,  14'h3FFC, 32'h5A5A_5A5A, SZ_WORD, 1, 32'h0000_0000, 1'b0);
    add_row(CMD_WRITE, 14'h0001, 32'h0000_00A5, SZ_BYTE, 1, 32'hFFFF_FFFF, 1'b0);
    add_row(CMD_READ,  14'h0000, 32'h0000_0000, SZ_WORD, 1, 32'hFFFF_A5FF, 1'b0);
    add_row(CMD_READ,  14'h0003, 32'h0000_0000, SZ_BYTE, 1, 32'h0000_00FF, 1'b0);
    // halfword at offset one stays inside the word
    add_row(CMD_WRITE, 14'h3FFD, 32'hFFFF_1234, SZ_HALF, 1, 32'h0000_0000, 1'b0);
    add_row(CMD_READ,  14'h3FFC, 32'h0000_0000, SZ_WORD, 1, 32'h0012_3400, 1'b0);
    // accesses crossing the word: flagged, no store
    add_row(CMD_WRITE, 14'h3FFF, 32'h0000_BEEF, SZ_HALF, 1, 32'h0012_3400, 1'b1);
    add_row(CMD_READ,  14'h3FFC, 32'h0000_0000, SZ_WORD, 1, 32'h0012_3400, 1'b0);
    add_row(CMD_WRITE, 14'h0002, 32'h1111_1111, SZ_WORD, 1, 32'hFFFF_A5FF, 1'b1);
    add_row(CMD_READ,  14'h0001, 32'h0000_0000, SZ_WORD, 1, 32'h00FF_FFA5, 1'b1);
    add_row(CMD_READ,  14'h0003, 32'h0000_0000, SZ_WORD, 1, 32'h0000_00FF, 1'b1);
    add_row(CMD_READ,  14'h0003, 32'h0000_0000, SZ_HALF, 1, 32'h0000_00FF, 1'b1);
    add_row(CMD_READ,  14'h0002, 32'h0000_0000, SZ_HALF, 0, '0, 1'b0);
    add_row(CMD_WRITE, 14'h0004, 32'hDEAD_BEEF, SZ_ALT_WORD, 0, '0, 1'b0);
    add_row(CMD_READ,  14'h0004, 32'h0000_0000, SZ_ALT_WORD, 1, 32'hDEAD_BEEF, 1'b0);
    add_row(CMD_READ,  14'h0006, 32'h0000_0000, SZ_ALT_WORD, 1, 32'h0000_DEAD, 1'b1);
    add_row(CMD_WRITE, 14'h0007, 32'hFFFF_FF00, SZ_BYTE, 1, 32'hDEAD_BEEF, 1'b0);
    add_row(CMD_READ,  14'h0006, 32'h0000_0000, SZ_HALF, 1, 32'h0000_00AD, 1'b0);
    add_row(CMD_READ,  14'h0005, 32'h0000_0000, SZ_BYTE, 0, '0, 1'b0);
    add_row(CMD_WRITE, 14'h0005, 32'hCAFE_F00D, SZ_HALF, 0, '0, 1'b0);
    add_row(CMD_READ,  14'h0004, 32'h0000_0000, SZ_WORD, 0, '0, 1'b0);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_access(row.acc, row.typed, row.read_data, row.misaligned);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (known_words.size() == 0 || $urandom_range(0, 99) < 20) begin
        idx = $urandom_range(0, WORDS - 1);
      end else begin
        idx = known_words[$urandom_range(0, known_words.size() - 1)];
      end
      acc.wdata = $urandom;
      if (lane_known[idx] != 4'hF) begin
        // fresh word: fill it with an aligned full-word write
        acc.cmd  = CMD_WRITE;
        acc.size = $urandom_range(0, 1) ? SZ_WORD : SZ_ALT_WORD;
        off      = 2'd0;
      end else begin
        acc.cmd  = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
        acc.size = 2'($urandom_range(0, 3));
        off      = 2'($urandom_range(0, 3));
      end
      acc.addr = {12'(idx), off};
      send_access(acc, 0, '0, 1'b0);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
